// ===== sv/stbs_pkg.sv =====
`default_nettype none

package stbs_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned DefKeyWidth   = 32;

  // Field widths of the request and result items.
  localparam int unsigned LenW      = 11;
  localparam int unsigned IdxFieldW = 10;
  localparam int unsigned KeyFieldW = 32;
  localparam int unsigned PosW      = 10;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;

  // Request commands.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Search variants.
  localparam logic VARIANT_FORGETFUL   = 1'b0;
  localparam logic VARIANT_RECOGNIZING = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_LIST_LENGTH    = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SEARCH_VARIANT = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [IdxFieldW-1:0] entry_index;
    logic [KeyFieldW-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FINAL,
    ST_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;
    logic start;
    logic step;
    logic final_chk;
    logic ld_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic start_loop;
    logic step_more;
    logic step_final;
  } dp_status_t;

  // Midpoint of the range [lo, hi): (lo + hi - 1) / 2.
  function automatic logic [LenW-1:0] mid_of(input logic [LenW-1:0] lo,
                                             input logic [LenW-1:0] hi);
    logic [LenW:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} - (LenW + 1)'(1);
    return sum[LenW:1];
  endfunction

endpackage

`default_nettype wire

// ===== sv/stbs_ctrl.sv =====
`default_nettype none

module stbs_ctrl import stbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_cmd_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            priority if (status_i.empty) begin
              state_d = ST_DONE;
            end else if (status_i.start_loop) begin
              state_d = ST_STEP;
            end else begin
              state_d = ST_FINAL;
            end
          end
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        priority if (status_i.step_more) begin
          state_d = ST_STEP;
        end else if (status_i.step_final) begin
          state_d = ST_FINAL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FINAL: begin
        cmd_o.final_chk = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        // Wait until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
    endcase
  end

  // The output register is full after a load and empties when taken.
  assign out_valid_d = cmd_o.ld_out | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/stbs_datapath.sv =====
`default_nettype none

module stbs_datapath import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned KEY_WIDTH   = DefKeyWidth
) (
  input  logic            clk_i,
  input  in_item_t        in_data_i,
  input  logic [LenW-1:0] list_len_i,
  input  logic            variant_i,
  input  dp_cmd_t         cmd_i,
  output dp_status_t      status_o,
  output out_item_t       out_data_o
);

  localparam int unsigned AddrW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [31:0] DepthVal = 32'(TABLE_DEPTH);

  logic [KEY_WIDTH-1:0] mem_q [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rd_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [LenW-1:0]      low_q, low_d;
  logic [LenW-1:0]      high_q, high_d;
  logic [LenW-1:0]      mid_q, mid_d;
  logic [LenW-1:0]      nlow, nhigh;
  logic                 forgetful;
  logic                 lt, eq, more;
  logic                 wr_ok;
  logic [AddrW-1:0]     rd_addr, wr_addr;
  out_item_t            res_q, res_d, out_q;

  // Compare the entry just read and narrow the range.
  always_comb begin
    forgetful = (variant_i == VARIANT_FORGETFUL);
    lt        = rd_q < key_q;
    eq        = rd_q == key_q;
    nlow      = lt ? mid_q + LenW'(1) : low_q;
    if (lt) begin
      nhigh = high_q;
    end else if (forgetful) begin
      nhigh = mid_q + LenW'(1);
    end else begin
      nhigh = mid_q;
    end
    if (forgetful) begin
      more = ({1'b0, nlow} + (LenW + 1)'(1)) < {1'b0, nhigh};
    end else begin
      more = nlow < nhigh;
    end
  end

  // Status for the controller.
  always_comb begin
    status_o.empty      = (list_len_i == '0);
    status_o.start_loop = forgetful ? (list_len_i > LenW'(1)) : 1'b1;
    status_o.step_more  = more && !(!forgetful && eq);
    status_o.step_final = forgetful && !more;
  end

  // Bounds, next read address and pending result.
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    mid_d  = mid_q;
    res_d  = res_q;
    priority if (cmd_i.start) begin
      low_d  = '0;
      high_d = list_len_i;
      mid_d  = mid_of(LenW'(0), list_len_i);
      res_d  = '0;
    end else if (cmd_i.step) begin
      low_d          = nlow;
      high_d         = nhigh;
      mid_d          = (forgetful && !more) ? nlow : mid_of(nlow, nhigh);
      res_d.found    = eq;
      res_d.position = PosW'(mid_q);
    end else if (cmd_i.final_chk) begin
      res_d.found    = eq;
      res_d.position = PosW'(low_q);
    end
    rd_addr = AddrW'(mid_d);
    wr_ok   = cmd_i.wr_en && (32'(in_data_i.entry_index) < DepthVal);
    wr_addr = AddrW'(in_data_i.entry_index);
  end

  // Table memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_addr] <= KEY_WIDTH'(in_data_i.key_value);
    end
    rd_q <= mem_q[rd_addr];
  end

  // Search registers and result staging.
  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    high_q <= high_d;
    mid_q  <= mid_d;
    res_q  <= res_d;
    if (cmd_i.start) begin
      key_q <= KEY_WIDTH'(in_data_i.key_value);
    end
    if (cmd_i.ld_out) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== sv/sorted_table_binary_search_unit.sv =====
`default_nettype none

// Channel  Direction  Signals                                 Carries
// in       input      in_valid_i / in_ready_o / in_data_i     write or search request
// out      output     out_valid_o / out_ready_i / out_data_o  found and position
// cfg      input      cfg_valid_i / cfg_ready_o / cfg_index_i list_length, search_variant
//                     cfg_data_i
//
// A write request leaves the block ready for the next request; a search of n entries makes one
// table read per halving step in forgetful or recognizing mode; an empty list needs no step.
// Reset clears the controller and the configuration; the table is not cleared.
// A result waiting in the output register does not stall new requests; a finished
// search waits only when the previous result has not been taken.

module sorted_table_binary_search_unit import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned KEY_WIDTH   = DefKeyWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [31:0] DepthVal = 32'(TABLE_DEPTH);

  logic [LenW-1:0] list_length_q;
  logic            variant_q;
  logic [LenW-1:0] list_len_sat;
  dp_cmd_t         dp_cmd;
  dp_status_t      dp_status;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_length_q <= '0;
      variant_q     <= VARIANT_FORGETFUL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LIST_LENGTH:    list_length_q <= LenW'(cfg_data_i);
        CFG_SEARCH_VARIANT: variant_q     <= cfg_data_i[0];
      endcase
    end
  end

  // A length beyond the table is clipped to the table depth.
  assign list_len_sat = (32'(list_length_q) > DepthVal) ? LenW'(TABLE_DEPTH) : list_length_q;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .list_len_i (list_len_sat),
    .variant_i  (variant_q),
    .cmd_i      (dp_cmd),
    .status_o   (dp_status),
    .out_data_o (out_data_o)
  );

  // An accepted search keeps the block busy in the following cycle.
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_o && in_data_i.cmd == CMD_SEARCH) |=> !in_ready_o)
    else $error("search request did not occupy the block");

  // A write request never produces a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_o && in_data_i.cmd == CMD_WRITE && !out_valid_o)
      |=> !out_valid_o)
    else $error("write request produced a result");

  // An empty list answers not found at position zero.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && list_len_sat == '0) |->
      (!out_data_o.found && out_data_o.position == '0))
    else $error("empty list gave a nonzero result");

  // A hit always lies inside the list.
  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_data_o.found) |-> (LenW'(out_data_o.position) < list_len_sat))
    else $error("hit reported outside the list");

endmodule

`default_nettype wire
